/* hdl/light_level_stepped_regulator_unit_macros.svh */
// assertion macros for the light level stepped regulator
`ifndef LIGHT_LEVEL_STEPPED_REGULATOR_UNIT_MACROS_SVH
`define LIGHT_LEVEL_STEPPED_REGULATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsr assertion failed");

// next-cycle implication, disabled during reset
`define LSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsr assertion failed");

`endif

/* hdl/lsr_pkg.sv */
// types, constants and helper functions for the light level stepped regulator
`timescale 1ns / 1ps
`default_nettype none

package lsr_pkg;

    localparam int AVG_W   = 16;
    localparam int DRIVE_W = 8;
    localparam int INDEX_W = 5;
    localparam int TARGET_W = 10;

    localparam logic [INDEX_W-1:0]  FORCED_INDEX  = 5'd16;
    localparam logic [TARGET_W-1:0] TARGET_RESET  = 10'd1023;
    localparam logic [DRIVE_W-1:0]  DRIVE_RESET   = 8'd255;
    localparam logic [DRIVE_W-1:0]  DRIVE_MAX     = 8'd255;
    localparam logic [3:0]          INVALID_NIBBLE = 4'hF;
    localparam int                  NO_SELECT_BIT = 6;

    typedef logic signed [17:0] lsr_diff_t;
    typedef logic signed [5:0]  lsr_step_t;

    localparam lsr_diff_t BAND_30 = 18'sd120;
    localparam lsr_diff_t BAND_20 = 18'sd80;
    localparam lsr_diff_t BAND_10 = 18'sd40;
    localparam lsr_diff_t BAND_5  = 18'sd20;
    localparam lsr_diff_t BAND_2  = 18'sd8;

    typedef struct packed {
        logic [7:0] a_hi;
        logic [7:0] a_lo;
        logic [7:0] b_hi;
        logic [7:0] b_lo;
        logic [7:0] st_hi;
        logic [7:0] st_lo;
    } lsr_packet_t;

    typedef struct packed {
        logic [AVG_W-1:0]    avg_a;
        logic [AVG_W-1:0]    avg_b;
        logic [DRIVE_W-1:0]  drive;
        logic [INDEX_W-1:0]  active_index;
        logic [TARGET_W-1:0] target;
    } lsr_state_t;

    typedef struct packed {
        logic [DRIVE_W-1:0]  drive_level;
        logic [AVG_W-1:0]    mean_level;
        logic [TARGET_W-1:0] target_level;
        logic                sample_taken;
    } lsr_result_t;

    localparam lsr_state_t STATE_RESET = '{
        avg_a: '0,
        avg_b: '0,
        drive: DRIVE_RESET,
        active_index: FORCED_INDEX,
        target: TARGET_RESET
    };

    // percent setting times 1023 over 100, precomputed per index
    function automatic logic [TARGET_W-1:0] target_lookup(input logic [INDEX_W-1:0] idx);
        logic [TARGET_W-1:0] t;
        unique case (idx)
            5'd0:    t = 10'd1023;
            5'd1:    t = 10'd767;
            5'd2:    t = 10'd511;
            5'd3:    t = 10'd255;
            5'd4:    t = 10'd818;
            5'd5:    t = 10'd613;
            5'd6:    t = 10'd409;
            5'd7:    t = 10'd204;
            5'd8:    t = 10'd613;
            5'd9:    t = 10'd460;
            5'd10:   t = 10'd306;
            5'd11:   t = 10'd153;
            5'd12:   t = 10'd409;
            5'd13:   t = 10'd306;
            5'd14:   t = 10'd204;
            5'd15:   t = 10'd102;
            default: t = TARGET_RESET;
        endcase
        return t;
    endfunction

    // move avg halfway toward sample, half-difference truncated toward zero
    function automatic logic [AVG_W-1:0] pull_half(input logic [AVG_W-1:0] avg,
                                                   input logic [AVG_W-1:0] sample);
        logic signed [AVG_W:0] diff;
        logic signed [AVG_W:0] adj;
        logic signed [AVG_W:0] half;
        logic signed [AVG_W:0] sum;
        diff = $signed({1'b0, sample}) - $signed({1'b0, avg});
        adj  = diff + $signed({{AVG_W{1'b0}}, diff[AVG_W]});
        half = adj >>> 1;
        sum  = $signed({1'b0, avg}) + half;
        return sum[AVG_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/light_level_stepped_regulator_unit.sv */
// top level of the light level stepped regulator: handshake, state and result registers
// usage:
//   input channel in_valid/in_ready carries one six-byte sensor packet per item
//   output channel out_valid/out_ready carries one result item per packet
//   an accepted packet is held in the input register until the output register
//   is free or being read, then its result is loaded into the output register
//   throughput is one item per cycle while out_ready is high; the running averages,
//   drive level and target are updated as each item moves into the output register,
//   so back-to-back items see each other's updates in order
//   while the receiver stalls, the result holds and the input register
//   still takes one more item; in_ready drops only when both are full
//   reset clears both valid flags, sets averages to zero, drive to 255,
//   active index to "no selection" and target to 1023
`timescale 1ns / 1ps
`default_nettype none

module light_level_stepped_regulator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  sensor_a_high,
    input  wire logic [7:0]  sensor_a_low,
    input  wire logic [7:0]  sensor_b_high,
    input  wire logic [7:0]  sensor_b_low,
    input  wire logic [7:0]  status_hi_byte,
    input  wire logic [7:0]  status_lo_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       drive_level,
    output logic [15:0]      mean_level,
    output logic [9:0]       target_level,
    output logic             sample_taken
);
    import lsr_pkg::*;

    `include "light_level_stepped_regulator_unit_macros.svh"

    logic        in_valid_reg;
    lsr_packet_t pkt_reg;
    lsr_state_t  state_reg;
    lsr_state_t  state_next;
    logic        out_valid_reg;
    lsr_result_t result_reg;
    lsr_result_t result_next;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    lsr_step u_step (
        .pkt        (pkt_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pkt_reg <= '{a_hi: sensor_a_high, a_lo: sensor_a_low,
                         b_hi: sensor_b_high, b_lo: sensor_b_low,
                         st_hi: status_hi_byte, st_lo: status_lo_byte};
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_level  = result_reg.drive_level;
    assign mean_level   = result_reg.mean_level;
    assign target_level = result_reg.target_level;
    assign sample_taken = result_reg.sample_taken;

    `LSR_ASSERT_NEXT(a_hold_on_invalid, clk, rst_n, advance && !result_next.sample_taken, $stable(state_reg.avg_a) && $stable(state_reg.avg_b) && $stable(state_reg.drive))
    `LSR_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_valid_reg, in_ready)
    `LSR_ASSERT_IMP(a_no_select_target, clk, rst_n, state_reg.active_index == FORCED_INDEX, state_reg.target == TARGET_RESET)

endmodule

`default_nettype wire

/* hdl/lsr_step.sv */
// combinational update of regulator state for one sensor packet
`timescale 1ns / 1ps
`default_nettype none

module lsr_step (
    input  lsr_pkg::lsr_packet_t pkt,
    input  lsr_pkg::lsr_state_t  state,
    output lsr_pkg::lsr_state_t  state_next,
    output lsr_pkg::lsr_result_t result
);
    import lsr_pkg::*;

    logic [INDEX_W-1:0]  idx;
    logic [TARGET_W-1:0] target_now;
    logic                sensors_ok;
    logic [AVG_W-1:0]    avg_a_now;
    logic [AVG_W-1:0]    avg_b_now;
    logic [AVG_W:0]      avg_sum;
    logic [AVG_W-1:0]    mean;
    lsr_diff_t           d;
    lsr_step_t           step;
    logic signed [9:0]   drive_sum;
    logic [DRIVE_W-1:0]  drive_adj;
    logic [DRIVE_W-1:0]  drive_now;

    always_comb
    begin
        if (pkt.st_lo[NO_SELECT_BIT])
        begin
            idx = FORCED_INDEX;
        end
        else
        begin
            idx = {1'b0, pkt.st_hi[1:0], pkt.st_lo[1:0]};
        end
        target_now = (idx != state.active_index) ? target_lookup(idx) : state.target;

        sensors_ok = (pkt.a_hi[7:4] != INVALID_NIBBLE) && (pkt.b_hi[7:4] != INVALID_NIBBLE);
        avg_a_now  = sensors_ok ? pull_half(state.avg_a, {pkt.a_hi, pkt.a_lo}) : state.avg_a;
        avg_b_now  = sensors_ok ? pull_half(state.avg_b, {pkt.b_hi, pkt.b_lo}) : state.avg_b;
        avg_sum    = {1'b0, avg_a_now} + {1'b0, avg_b_now};
        mean       = avg_sum[AVG_W:1];

        d = $signed({2'b00, mean}) - $signed({8'b0, target_now});
        if (d < -BAND_30)      step = 6'sd30;
        else if (d < -BAND_20) step = 6'sd20;
        else if (d < -BAND_10) step = 6'sd10;
        else if (d < -BAND_5)  step = 6'sd5;
        else if (d < -BAND_2)  step = 6'sd2;
        else if (d > BAND_30)  step = -6'sd30;
        else if (d > BAND_20)  step = -6'sd20;
        else if (d > BAND_10)  step = -6'sd10;
        else if (d > BAND_5)   step = -6'sd5;
        else if (d > BAND_2)   step = -6'sd2;
        else                   step = 6'sd0;

        drive_sum = $signed({2'b00, state.drive}) + $signed({{4{step[5]}}, step});
        if (drive_sum < 10'sd0)
        begin
            drive_adj = '0;
        end
        else if (drive_sum > $signed({2'b00, DRIVE_MAX}))
        begin
            drive_adj = DRIVE_MAX;
        end
        else
        begin
            drive_adj = drive_sum[DRIVE_W-1:0];
        end
        drive_now = sensors_ok ? drive_adj : state.drive;

        state_next.avg_a        = avg_a_now;
        state_next.avg_b        = avg_b_now;
        state_next.drive        = drive_now;
        state_next.active_index = idx;
        state_next.target       = target_now;

        result.drive_level  = drive_now;
        result.mean_level   = mean;
        result.target_level = target_now;
        result.sample_taken = sensors_ok;
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// light level stepped regulator testbench: directed and random sensor packets checked by a predictor
`timescale 1ns / 1ps

module tb_top;
    import lsr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  sensor_a_high;
    logic [7:0]  sensor_a_low;
    logic [7:0]  sensor_b_high;
    logic [7:0]  sensor_b_low;
    logic [7:0]  status_hi_byte;
    logic [7:0]  status_lo_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  drive_level;
    logic [15:0] mean_level;
    logic [9:0]  target_level;
    logic        sample_taken;

    light_level_stepped_regulator_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sensor_a_high  (sensor_a_high),
        .sensor_a_low   (sensor_a_low),
        .sensor_b_high  (sensor_b_high),
        .sensor_b_low   (sensor_b_low),
        .status_hi_byte (status_hi_byte),
        .status_lo_byte (status_lo_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_level    (drive_level),
        .mean_level     (mean_level),
        .target_level   (target_level),
        .sample_taken   (sample_taken)
    );

    lsr_packet_t pending_packets[$];
    lsr_result_t expected_results[$];

    // predicted regulator state
    logic [15:0] lvl_avg_a  = '0;
    logic [15:0] lvl_avg_b  = '0;
    logic [7:0]  lvl_drive  = DRIVE_RESET;
    logic [4:0]  lvl_index  = FORCED_INDEX;
    logic [9:0]  lvl_target = TARGET_RESET;

    int gen_index     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req     = 0;
    int stall_ack     = 0;
    int stall_left    = 0;
    int sent_cnt      = 0;
    int checked_cnt   = 0;
    int taken_cnt     = 0;
    int err_cnt       = 0;

    function automatic int percent_of(input int idx);
        int pct;
        case (idx)
            0:       pct = 100;
            1:       pct = 75;
            2:       pct = 50;
            3:       pct = 25;
            4:       pct = 80;
            5:       pct = 60;
            6:       pct = 40;
            7:       pct = 20;
            8:       pct = 60;
            9:       pct = 45;
            10:      pct = 30;
            11:      pct = 15;
            12:      pct = 40;
            13:      pct = 30;
            14:      pct = 20;
            15:      pct = 10;
            default: pct = 100;
        endcase
        return pct;
    endfunction

    function automatic logic [15:0] halfway_toward(input logic [15:0] avg,
                                                   input logic [15:0] reading);
        int gap;
        gap = int'(reading) - int'(avg);
        return 16'(int'(avg) + gap / 2);
    endfunction

    function automatic lsr_result_t regulate(input lsr_packet_t p);
        logic [4:0]  idx;
        int          mean;
        int          d;
        int          step;
        int          v;
        lsr_result_t r;
        idx = {1'b0, p.st_hi[1:0], p.st_lo[1:0]};
        if (p.st_lo[NO_SELECT_BIT])
            idx = FORCED_INDEX;
        if (idx != lvl_index)
        begin
            lvl_target = 10'(percent_of(int'(idx)) * 1023 / 100);
            lvl_index  = idx;
        end
        r.sample_taken = 1'b0;
        if (p.a_hi[7:4] != INVALID_NIBBLE && p.b_hi[7:4] != INVALID_NIBBLE)
        begin
            lvl_avg_a = halfway_toward(lvl_avg_a, {p.a_hi, p.a_lo});
            lvl_avg_b = halfway_toward(lvl_avg_b, {p.b_hi, p.b_lo});
            mean = (int'(lvl_avg_a) + int'(lvl_avg_b)) / 2;
            d = mean - int'(lvl_target);
            if (d < -120)      step = 30;
            else if (d < -80)  step = 20;
            else if (d < -40)  step = 10;
            else if (d < -20)  step = 5;
            else if (d < -8)   step = 2;
            else if (d > 120)  step = -30;
            else if (d > 80)   step = -20;
            else if (d > 40)   step = -10;
            else if (d > 20)   step = -5;
            else if (d > 8)    step = -2;
            else               step = 0;
            v = int'(lvl_drive) + step;
            if (v > int'(DRIVE_MAX))
                v = int'(DRIVE_MAX);
            if (v < 0)
                v = 0;
            lvl_drive = 8'(v);
            r.sample_taken = 1'b1;
        end
        r.drive_level  = lvl_drive;
        r.mean_level   = 16'((int'(lvl_avg_a) + int'(lvl_avg_b)) / 2);
        r.target_level = lvl_target;
        return r;
    endfunction

    // mostly readings near the target of a sticky setting, some raw noise and invalid data
    function automatic lsr_packet_t random_packet();
        int          mode;
        int          tgt;
        int          va;
        int          vb;
        logic [15:0] ra;
        logic [15:0] rb;
        logic [7:0]  lo;
        lsr_packet_t p;
        if ($urandom_range(9) == 0)
            gen_index = $urandom_range(16);
        tgt  = percent_of(gen_index) * 1023 / 100;
        mode = $urandom_range(9);
        if (mode < 6)
        begin
            va = tgt + int'($urandom_range(400)) - 200;
            vb = tgt + int'($urandom_range(400)) - 200;
            if (va < 0)
                va = 0;
            if (vb < 0)
                vb = 0;
            ra = 16'(va);
            rb = 16'(vb);
        end
        else
        begin
            ra = 16'($urandom_range(16'hFFFF));
            rb = 16'($urandom_range(16'hFFFF));
        end
        if (mode == 9)
        begin
            if ($urandom_range(1) == 1)
                ra[15:12] = INVALID_NIBBLE;
            else
                rb[15:12] = INVALID_NIBBLE;
        end
        p.a_hi = ra[15:8];
        p.a_lo = ra[7:0];
        p.b_hi = rb[15:8];
        p.b_lo = rb[7:0];
        p.st_hi = 8'($urandom_range(255));
        lo = 8'($urandom_range(255));
        lo[NO_SELECT_BIT] = (gen_index == int'(FORCED_INDEX));
        if (gen_index != int'(FORCED_INDEX))
        begin
            p.st_hi[1:0] = 2'(gen_index >> 2);
            lo[1:0]      = 2'(gen_index);
        end
        p.st_lo = lo;
        return p;
    endfunction

    task automatic queue_packet(input logic [7:0] ah, input logic [7:0] al,
                                input logic [7:0] bh, input logic [7:0] bl,
                                input logic [7:0] sh, input logic [7:0] sl);
        pending_packets.push_back({ah, al, bh, bl, sh, sl});
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            pending_packets.push_back(random_packet());
    endtask

    task automatic drain();
        while (pending_packets.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            sensor_a_high  <= '0;
            sensor_a_low   <= '0;
            sensor_b_high  <= '0;
            sensor_b_low   <= '0;
            status_hi_byte <= '0;
            status_lo_byte <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(regulate({sensor_a_high, sensor_a_low,
                                                     sensor_b_high, sensor_b_low,
                                                     status_hi_byte, status_lo_byte}));
                sent_cnt++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_packets.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    lsr_packet_t p;
                    p = pending_packets.pop_front();
                    in_valid       <= 1'b1;
                    sensor_a_high  <= p.a_hi;
                    sensor_a_low   <= p.a_lo;
                    sensor_b_high  <= p.b_hi;
                    sensor_b_low   <= p.b_lo;
                    status_hi_byte <= p.st_hi;
                    status_lo_byte <= p.st_lo;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_req != stall_ack)
        begin
            stall_ack  <= stall_req;
            stall_left <= 80;
            out_ready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("error: unexpected item drive=%0d mean=%0d target=%0d taken=%0b",
                             drive_level, mean_level, target_level, sample_taken);
            end
            else
            begin
                lsr_result_t e;
                e = expected_results.pop_front();
                checked_cnt++;
                if (sample_taken)
                    taken_cnt++;
                if (e.drive_level != drive_level || e.mean_level != mean_level ||
                    e.target_level != target_level || e.sample_taken != sample_taken)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("error: item %0d expected drive=%0d mean=%0d target=%0d taken=%0b, got drive=%0d mean=%0d target=%0d taken=%0b",
                                 checked_cnt, e.drive_level, e.mean_level, e.target_level,
                                 e.sample_taken, drive_level, mean_level, target_level,
                                 sample_taken);
                end
            end
        end
    end

    initial
    begin
        int mark;
        rst_n = 1'b0;
        send_idle_pct = 14;
        recv_idle_pct = 75;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: saturation both ways, invalid sensors, forced index, small target
        queue_packet(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (10) queue_packet(8'hEF, 8'hFF, 8'hEF, 8'hFF, 8'h00, 8'h00);
        queue_packet(8'hF0, 8'h12, 8'h10, 8'h34, 8'h03, 8'h03);
        queue_packet(8'h10, 8'h00, 8'hFF, 8'hFF, 8'hFC, 8'h40);
        queue_packet(8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h03);
        queue_packet(8'h00, 8'h66, 8'h00, 8'h66, 8'h03, 8'hBF);
        queue_packet(8'h0F, 8'hFF, 8'hE0, 8'h00, 8'h02, 8'h01);
        queue_packet(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_packet(8'h01, 8'h32, 8'h01, 8'h32, 8'h01, 8'h02);
        queue_packet(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        drain();

        queue_random(300);
        drain();

        send_idle_pct = 75;
        recv_idle_pct = 14;
        queue_random(300);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        mark = sent_cnt + 60;
        queue_random(300);
        while (sent_cnt < mark)
            @(negedge clk);
        stall_req = stall_req + 1;
        drain();

        repeat (10) @(negedge clk);
        $display("checked %0d of %0d packets, %0d with a regulation update, %0d held",
                 checked_cnt, sent_cnt, taken_cnt, checked_cnt - taken_cnt);
        $display("idling phases: sender-light, receiver-light, none with a long output stall");
        if (err_cnt == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d results missing", err_cnt, expected_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
